// File: sv/ntc_pkg.sv
// Package for the numeric token classifier: scan phase codes, verdict codes,
// character constants and the per-byte grammar step function.
// No dependencies.
`timescale 1ns / 1ps

package ntc_pkg;

  // Scan phase codes
  localparam int PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_START   = 4'd0;
  localparam logic [PhaseW-1:0] PH_SIGNED  = 4'd1;
  localparam logic [PhaseW-1:0] PH_ZERO    = 4'd2;
  localparam logic [PhaseW-1:0] PH_HEX     = 4'd3;
  localparam logic [PhaseW-1:0] PH_INT     = 4'd4;
  localparam logic [PhaseW-1:0] PH_DOT     = 4'd5;
  localparam logic [PhaseW-1:0] PH_FRAC    = 4'd6;
  localparam logic [PhaseW-1:0] PH_EXP     = 4'd7;
  localparam logic [PhaseW-1:0] PH_EXPSIGN = 4'd8;
  localparam logic [PhaseW-1:0] PH_EXPDIG  = 4'd9;

  // Verdict codes
  localparam int KindW = 2;
  localparam logic [KindW-1:0] KIND_TEXT  = 2'd0;
  localparam logic [KindW-1:0] KIND_INT   = 2'd1;
  localparam logic [KindW-1:0] KIND_FLOAT = 2'd2;

  // Stream widths
  localparam int ChW       = 8;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 8;

  // Character constants
  localparam logic [ChW-1:0] CH_NUL   = 8'h00;
  localparam logic [ChW-1:0] CH_TAB   = 8'h09;
  localparam logic [ChW-1:0] CH_CR    = 8'h0D;
  localparam logic [ChW-1:0] CH_SPACE = 8'h20;
  localparam logic [ChW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ChW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ChW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_NINE  = 8'h39;
  localparam logic [ChW-1:0] CH_UP_A  = 8'h41;
  localparam logic [ChW-1:0] CH_UP_E  = 8'h45;
  localparam logic [ChW-1:0] CH_UP_F  = 8'h46;
  localparam logic [ChW-1:0] CH_UP_X  = 8'h58;
  localparam logic [ChW-1:0] CH_LO_A  = 8'h61;
  localparam logic [ChW-1:0] CH_LO_E  = 8'h65;
  localparam logic [ChW-1:0] CH_LO_F  = 8'h66;
  localparam logic [ChW-1:0] CH_LO_X  = 8'h78;

  // Chained phase moves within one byte (start, signed, then int)
  localparam int ChainSteps = 3;

  // Scanner state carried between bytes
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              seen_number;
    logic              seen_float;
  } scan_st_t;

  // Outcome of feeding one byte
  typedef struct packed {
    scan_st_t         st;
    logic             done;
    logic [KindW-1:0] kind;
  } scan_res_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } item_t;

  // Result handed from the scanner to the output register
  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
  } verdict_t;

  function automatic logic is_dec(logic [ChW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(logic [ChW-1:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_blank(logic [ChW-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_exp(logic [ChW-1:0] c);
    return (c == CH_LO_E) || (c == CH_UP_E);
  endfunction

  function automatic logic is_sign(logic [ChW-1:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

  // Feed one byte into the grammar; done marks a fixed verdict
  function automatic scan_res_t scan_feed(scan_st_t s, logic [ChW-1:0] c);
    scan_res_t r;
    logic      go;
    logic      fin;
    r      = '0;
    r.st   = s;
    r.kind = KIND_TEXT;
    go     = 1'b1;
    fin    = 1'b0;
    for (int i = 0; i < ChainSteps; i++) begin
      if (go) begin
        go = 1'b0;
        case (r.st.phase)
          PH_START: begin
            r.st.phase = PH_SIGNED;
            go = !is_sign(c);
          end
          PH_SIGNED: begin
            if (c == CH_ZERO) begin
              r.st.seen_number = 1'b1;
              r.st.phase = PH_ZERO;
            end else begin
              r.st.phase = PH_INT;
              go = 1'b1;
            end
          end
          PH_ZERO: begin
            if ((c == CH_LO_X) || (c == CH_UP_X)) begin
              r.st.phase = PH_HEX;
            end else begin
              r.st.phase = PH_INT;
              go = 1'b1;
            end
          end
          PH_HEX: begin
            if (is_hex(c)) r.st.seen_number = 1'b1;
            else fin = 1'b1;
          end
          PH_INT: begin
            if (is_dec(c)) r.st.seen_number = 1'b1;
            else if (c == CH_DOT) r.st.phase = PH_DOT;
            else if (r.st.seen_number && is_exp(c)) r.st.phase = PH_EXP;
            else fin = 1'b1;
          end
          PH_DOT: begin
            if (is_dec(c)) begin
              r.st.seen_number = 1'b1;
              r.st.seen_float  = 1'b1;
              r.st.phase       = PH_FRAC;
            end else if (r.st.seen_number && is_exp(c)) begin
              r.st.phase = PH_EXP;
            end else begin
              fin = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_exp(c)) r.st.phase = PH_EXP;
            else if (!is_dec(c)) fin = 1'b1;
          end
          PH_EXP: begin
            r.st.phase = PH_EXPSIGN;
            go = !is_sign(c);
          end
          PH_EXPSIGN: begin
            if (is_dec(c)) begin
              r.st.seen_float = 1'b1;
              r.st.phase      = PH_EXPDIG;
            end else begin
              fin = 1'b1;
            end
          end
          PH_EXPDIG: begin
            if (!is_dec(c)) fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
    end
    // Breaking byte: a terminator keeps the number, anything else is text
    if (fin) begin
      r.done = 1'b1;
      if (r.st.seen_number && ((c == CH_NUL) || is_blank(c)))
        r.kind = r.st.seen_float ? KIND_FLOAT : KIND_INT;
      else
        r.kind = KIND_TEXT;
    end
    return r;
  endfunction

endpackage

// File: sv/ntc_scan.sv
// Scanner state for the numeric token classifier: phase and flags per string,
// verdict generation and rearm on the last byte. Depends on ntc_pkg.
`timescale 1ns / 1ps

module ntc_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,   // item leaves the input register
  input  ntc_pkg::item_t   item_i,
  output ntc_pkg::verdict_t verdict_o
);
  import ntc_pkg::*;

  scan_st_t  st_q, st_d;
  logic      sent_q, sent_d;
  scan_res_t first_res;
  scan_res_t end_res;
  scan_res_t res;

  // Byte step, then an implied terminator when the string ends still open
  always_comb begin
    first_res = scan_feed(st_q, item_i.ch);
    end_res   = scan_feed(first_res.st, CH_NUL);
    res       = (!first_res.done && item_i.last) ? end_res : first_res;
  end

  assign verdict_o.valid = !sent_q && res.done;
  assign verdict_o.kind  = res.kind;

  // Next state: rearm after the last byte, freeze once the verdict is out
  always_comb begin
    st_d   = st_q;
    sent_d = sent_q;
    if (step_i) begin
      if (item_i.last) begin
        st_d   = '{phase: PH_START, seen_number: 1'b0, seen_float: 1'b0};
        sent_d = 1'b0;
      end else if (!sent_q) begin
        st_d   = res.st;
        sent_d = res.done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '{phase: PH_START, seen_number: 1'b0, seen_float: 1'b0};
      sent_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      sent_q <= sent_d;
    end
  end

endmodule

// File: sv/numeric_token_classifier.sv
// A verdict is registered: the byte that fixes it waits in the input register and
// the verdict enters the result register, valid on the master side, as it steps on.
// Throughput: one byte per cycle while the result register is empty or drains; the
// phase step is one pass of shallow logic between the input register and the result
// register.
// Reset (rst_ni, asynchronous, active low) empties both registers and rearms
// the scanner at the start of a string.
`timescale 1ns / 1ps

module numeric_token_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave side: character stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ntc_pkg::InDataW-1:0]    s_axis_tdata,   // [7:0] ch
  input  logic                           s_axis_tlast,   // last
  // Master side: verdicts
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ntc_pkg::OutDataW-1:0]   m_axis_tdata    // [1:0] kind, rest zero
);
  import ntc_pkg::*;

  logic             in_valid_q, in_valid_d;
  item_t            in_item_q, in_item_d;
  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] out_kind_q, out_kind_d;
  logic             out_free;
  logic             step;
  verdict_t         verdict;

  // Pipeline advance: the result slot is empty or drains this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  ntc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .verdict_o (verdict)
  );

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (s_axis_tready) begin
      in_valid_d     = s_axis_tvalid;
      in_item_d.ch   = s_axis_tdata[ChW-1:0];
      in_item_d.last = s_axis_tlast;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    if (out_free) begin
      out_valid_d = step && verdict.valid;
      out_kind_d  = verdict.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_item_q  <= in_item_d;
    out_kind_q <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-KindW){1'b0}}, out_kind_q};

endmodule
